@@ sv/dab_pkg.sv @@
`timescale 1ns / 1ps
// Package with the types, codes and helper functions of the deadlock avoidance allocator.
package dab_pkg;

	localparam int NUM_PROCS     = 8;
	localparam int NUM_RES       = 4;
	localparam int COUNT_BITS    = 8;
	localparam int AMOUNT_FIELDS = 4;
	localparam int PROC_BITS     = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
	localparam int WORK_BITS     = COUNT_BITS + $clog2(NUM_PROCS + 1);

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [NUM_RES-1:0][COUNT_BITS-1:0] cvec_t;
	typedef logic [NUM_RES-1:0][WORK_BITS-1:0] wvec_t;

	localparam count_t COUNT_MAX = '1;

	localparam logic [2:0] OP_LOAD_AVAIL = 3'd0;
	localparam logic [2:0] OP_LOAD_MAX   = 3'd1;
	localparam logic [2:0] OP_REQUEST    = 3'd2;
	localparam logic [2:0] OP_RELEASE    = 3'd3;
	localparam logic [2:0] OP_END        = 3'd4;

	localparam logic [2:0] ST_DONE         = 3'd0;
	localparam logic [2:0] ST_WAIT_INSUFF  = 3'd1;
	localparam logic [2:0] ST_WAIT_UNSAFE  = 3'd2;
	localparam logic [2:0] ST_EXCEEDS_NEED = 3'd3;
	localparam logic [2:0] ST_BAD_RELEASE  = 3'd4;
	localparam logic [2:0] ST_BAD_OP       = 3'd5;

	localparam logic [2:0] CMD_NONE    = 3'd0;
	localparam logic [2:0] CMD_LOAD    = 3'd1;
	localparam logic [2:0] CMD_COMMIT  = 3'd2;
	localparam logic [2:0] CMD_RELEASE = 3'd3;
	localparam logic [2:0] CMD_END     = 3'd4;
	localparam logic [2:0] CMD_START   = 3'd5;

	typedef struct packed {
		logic [2:0]           act;
		logic [PROC_BITS-1:0] pid;
		cvec_t                amt;
	} cmd_t;

	typedef struct packed {
		logic  tok;
		logic  chg;
		wvec_t work;
	} link_t;

	typedef struct packed {
		logic  active;
		logic  done;
		cvec_t held;
		cvec_t need;
	} row_t;

	function automatic count_t sat_add(count_t a, count_t b);
		logic [COUNT_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
	endfunction

	function automatic count_t clamp_amt(logic [7:0] a);
		logic [23:0] v;
		v = {16'b0, a};
		if (v > 24'(COUNT_MAX)) return COUNT_MAX;
		return v[COUNT_BITS-1:0];
	endfunction

endpackage

@@ sv/dab_cell.sv @@
`timescale 1ns / 1ps
// One process cell: its claim rows and one step of the safety check chain.
module dab_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [dab_pkg::PROC_BITS-1:0]  idx,
	input  dab_pkg::cmd_t                  cmd,
	input  dab_pkg::link_t                 link_in,
	output dab_pkg::link_t                 link_out,
	output dab_pkg::row_t                  row
);
	import dab_pkg::*;

	cvec_t max_q, held_q, need_q;
	cvec_t held_t, need_t;
	logic  active_q, done_q;
	link_t link_q;
	logic  sel, fits, fit_now;
	wvec_t work_nx;

	always_comb begin
		sel = (cmd.pid == idx);
		fits = active_q && !done_q;
		for (int r = 0; r < NUM_RES; r++) begin
			held_t[r] = sel ? sat_add(held_q[r], cmd.amt[r]) : held_q[r];
			need_t[r] = sel ? (need_q[r] - cmd.amt[r]) : need_q[r];
			if (WORK_BITS'(need_t[r]) > link_in.work[r]) fits = 1'b0;
		end
		fit_now = link_in.tok && fits;
		for (int r = 0; r < NUM_RES; r++) begin
			work_nx[r] = fit_now ? (link_in.work[r] + WORK_BITS'(held_t[r])) : link_in.work[r];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q <= 1'b0;
			link_q <= '0;
			held_q <= '0;
		end else begin
			link_q.tok <= link_in.tok;
			link_q.chg <= link_in.chg || fit_now;
			link_q.work <= work_nx;
			if (fit_now) done_q <= 1'b1;
			case (cmd.act)
				CMD_START: begin
					done_q <= 1'b0;
				end
				CMD_LOAD: begin
					if (sel) begin
						held_q <= '0;
						active_q <= 1'b1;
					end
				end
				CMD_COMMIT: begin
					if (sel) held_q <= held_t;
				end
				CMD_RELEASE: begin
					if (sel) begin
						for (int r = 0; r < NUM_RES; r++) held_q[r] <= held_q[r] - cmd.amt[r];
					end
				end
				CMD_END: begin
					if (sel) begin
						held_q <= '0;
						active_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.act)
			CMD_LOAD: begin
				if (sel) begin
					max_q <= cmd.amt;
					need_q <= cmd.amt;
				end
			end
			CMD_COMMIT: begin
				if (sel) need_q <= need_t;
			end
			CMD_RELEASE: begin
				if (sel) begin
					for (int r = 0; r < NUM_RES; r++) need_q[r] <= sat_add(need_q[r], cmd.amt[r]);
				end
			end
			CMD_END: begin
				if (sel) need_q <= max_q;
			end
			default: ;
		endcase
	end

	assign link_out = link_q;
	assign row = '{active: active_q, done: done_q, held: held_q, need: need_q};

endmodule

@@ sv/deadlock_avoidance_allocator.sv @@
`timescale 1ns / 1ps
// Top level of the deadlock avoidance allocator built on a chain of process cells.
// Usage: each input request carries an operation, a process and four amounts; each
// produces exactly one status on the output channel. Both channels use valid and
// stall, and a request is taken when valid is high and stall is low.
// Loads, releases, ends and rejected requests skip the safety check: the status
// appears in the output register on the cycle after acceptance.
// A request that passes its checks runs the safety check: a work vector travels
// down the chain of NUM_PROCS cells, one cell per cycle, and is sent round again
// while any process was newly satisfied. There are at most NUM_PROCS + 1 passes,
// so the length of the chain sets how long a request can take.
// One request is worked on at a time. A new request is taken while a status waits,
// as long as the receiver is not stalling it at that moment.
// Reset clears the available vector, all held amounts and all running flags.
// While the receiver stalls, the status is held and no further request is taken.
module deadlock_avoidance_allocator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] operation,
	input  logic [2:0] process,
	input  logic [7:0] amount_0,
	input  logic [7:0] amount_1,
	input  logic [7:0] amount_2,
	input  logic [7:0] amount_3,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status
);
	import dab_pkg::*;

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_CHECK = 1'b1;

	logic                           state_q;
	logic                           out_valid_q;
	logic [2:0]                     status_q;
	cvec_t                          avail_q, avail_nx, amt_q, amt_in;
	logic [PROC_BITS-1:0]           pid_q, pid_in;
	link_t                          inj_q, start_link, last;
	link_t                          lk [NUM_PROCS+1];
	row_t                           rows [NUM_PROCS];
	row_t                           sel_row;
	cmd_t                           cmd;
	logic [2:0]                     acc_act, st_nx;
	logic                           acc, bad_proc, go_check, unsafe, finishing;
	logic [AMOUNT_FIELDS-1:0][7:0]  am_raw;
	logic [NUM_PROCS:0]             toks;

	assign am_raw = {amount_3, amount_2, amount_1, amount_0};

	for (genvar r = 0; r < NUM_RES; r++) begin : g_amt
		if (r < AMOUNT_FIELDS) begin : g_fld
			assign amt_in[r] = clamp_amt(am_raw[r]);
		end else begin : g_zero
			assign amt_in[r] = '0;
		end
	end

	assign lk[0] = inj_q;
	assign toks[0] = inj_q.tok;
	for (genvar i = 0; i < NUM_PROCS; i++) begin : g_cell
		dab_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (PROC_BITS'(i)),
			.cmd      (cmd),
			.link_in  (lk[i]),
			.link_out (lk[i+1]),
			.row      (rows[i])
		);
		assign toks[i+1] = lk[i+1].tok;
	end
	assign last = lk[NUM_PROCS];

	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign acc = in_valid && !in_stall;
	assign bad_proc = (int'(process) >= NUM_PROCS);
	assign pid_in = PROC_BITS'(process);
	assign sel_row = rows[pid_in];

	always_comb begin
		unsafe = 1'b0;
		for (int p = 0; p < NUM_PROCS; p++) begin
			if (rows[p].active && !rows[p].done) unsafe = 1'b1;
		end
		finishing = (state_q == ST_CHECK) && last.tok && !last.chg;
	end

	always_comb begin
		st_nx = ST_DONE;
		acc_act = CMD_NONE;
		go_check = 1'b0;
		avail_nx = avail_q;
		start_link.tok = 1'b1;
		start_link.chg = 1'b0;
		for (int r = 0; r < NUM_RES; r++) start_link.work[r] = WORK_BITS'(avail_q[r] - amt_in[r]);
		case (operation)
			OP_LOAD_AVAIL: begin
				avail_nx = amt_in;
			end
			OP_LOAD_MAX: begin
				if (bad_proc) st_nx = ST_BAD_OP;
				else acc_act = CMD_LOAD;
			end
			OP_REQUEST: begin
				if (bad_proc) begin
					st_nx = ST_BAD_OP;
				end else begin
					for (int r = 0; r < NUM_RES; r++) begin
						if (st_nx == ST_DONE) begin
							if (amt_in[r] > sel_row.need[r]) st_nx = ST_EXCEEDS_NEED;
							else if (amt_in[r] > avail_q[r]) st_nx = ST_WAIT_INSUFF;
						end
					end
					if (st_nx == ST_DONE) begin
						go_check = 1'b1;
						acc_act = CMD_START;
					end
				end
			end
			OP_RELEASE: begin
				if (bad_proc) begin
					st_nx = ST_BAD_OP;
				end else begin
					for (int r = 0; r < NUM_RES; r++) begin
						if (amt_in[r] > sel_row.held[r]) st_nx = ST_BAD_RELEASE;
					end
					if (st_nx == ST_DONE) begin
						acc_act = CMD_RELEASE;
						for (int r = 0; r < NUM_RES; r++) avail_nx[r] = sat_add(avail_q[r], amt_in[r]);
					end
				end
			end
			OP_END: begin
				if (bad_proc) begin
					st_nx = ST_BAD_OP;
				end else begin
					acc_act = CMD_END;
					for (int r = 0; r < NUM_RES; r++) avail_nx[r] = sat_add(avail_q[r], sel_row.held[r]);
				end
			end
			default: begin
				st_nx = ST_BAD_OP;
			end
		endcase
	end

	always_comb begin
		if (acc) begin
			cmd.act = acc_act;
			cmd.pid = pid_in;
			cmd.amt = amt_in;
		end else begin
			cmd.act = (finishing && !unsafe) ? CMD_COMMIT : CMD_NONE;
			cmd.pid = pid_q;
			cmd.amt = amt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			status_q <= ST_DONE;
			avail_q <= '0;
			inj_q <= '0;
		end else begin
			inj_q.tok <= 1'b0;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (acc) begin
				avail_q <= avail_nx;
				if (go_check) begin
					state_q <= ST_CHECK;
					inj_q <= start_link;
				end else begin
					out_valid_q <= 1'b1;
					status_q <= st_nx;
				end
			end else if (state_q == ST_CHECK && last.tok) begin
				if (last.chg) begin
					inj_q.tok <= 1'b1;
					inj_q.chg <= 1'b0;
					inj_q.work <= last.work;
				end else begin
					state_q <= ST_IDLE;
					out_valid_q <= 1'b1;
					status_q <= unsafe ? ST_WAIT_UNSAFE : ST_DONE;
					if (!unsafe) begin
						for (int r = 0; r < NUM_RES; r++) avail_q[r] <= avail_q[r] - amt_q[r];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pid_q <= pid_in;
			amt_q <= amt_in;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;

`ifndef ASSERT_OFF
	a_no_status_in_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> !out_valid_q)
		else $error("status pending while the safety check runs");
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(toks) <= 1)
		else $error("more than one work vector in the chain");
	a_avail_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && $past(state_q) == ST_CHECK) |-> $stable(avail_q))
		else $error("available vector changed during the safety check");
	a_idle_no_token: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && $past(state_q) == ST_IDLE) |-> !toks[0])
		else $error("work vector injected outside the safety check");
`endif

endmodule

@@ tb/sv/deadlock_avoidance_allocator_tb.sv @@
`timescale 1ns / 1ps
// Testbench of the deadlock avoidance allocator: queued requests, a status predictor and a checker.
module deadlock_avoidance_allocator_tb;
	import dab_pkg::*;

	typedef struct packed {
		logic [2:0] op;
		logic [2:0] pid;
		logic [7:0] a0;
		logic [7:0] a1;
		logic [7:0] a2;
		logic [7:0] a3;
	} req_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [2:0] operation;
	logic [2:0] process;
	logic [7:0] amount_0;
	logic [7:0] amount_1;
	logic [7:0] amount_2;
	logic [7:0] amount_3;
	logic       out_valid;
	logic       out_stall;
	logic [2:0] status;

	deadlock_avoidance_allocator u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .process(process), .amount_0(amount_0),
		.amount_1(amount_1), .amount_2(amount_2), .amount_3(amount_3),
		.out_valid(out_valid), .out_stall(out_stall), .status(status)
	);

	req_t       pending_reqs[$];
	logic [2:0] expected_status[$];
	int         mismatches = 0;
	int         sent = 0;
	int         checked = 0;
	int         send_idle_pct = 31;
	int         recv_idle_pct = 51;
	bit         hold_off = 0;
	bit         driving = 0;

	count_t     avail[NUM_RES];
	count_t     claim[NUM_PROCS][NUM_RES];
	count_t     held[NUM_PROCS][NUM_RES];
	count_t     need[NUM_PROCS][NUM_RES];
	bit         running[NUM_PROCS];

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic count_t add_sat(count_t a, count_t b);
		int s;
		s = int'(a) + int'(b);
		return (s > 255) ? count_t'(255) : count_t'(s);
	endfunction

	function automatic bit state_safe(count_t av[NUM_RES], count_t hl[NUM_PROCS][NUM_RES],
			count_t nd[NUM_PROCS][NUM_RES]);
		int  work[NUM_RES];
		bit  fin[NUM_PROCS];
		bit  changed;
		bit  fits;
		for (int r = 0; r < NUM_RES; r++) work[r] = av[r];
		for (int p = 0; p < NUM_PROCS; p++) fin[p] = 0;
		changed = 1;
		while (changed) begin
			changed = 0;
			for (int p = 0; p < NUM_PROCS; p++) begin
				if (running[p] && !fin[p]) begin
					fits = 1;
					for (int r = 0; r < NUM_RES; r++)
						if (nd[p][r] > work[r]) fits = 0;
					if (fits) begin
						for (int r = 0; r < NUM_RES; r++) work[r] += hl[p][r];
						fin[p] = 1;
						changed = 1;
					end
				end
			end
		end
		for (int p = 0; p < NUM_PROCS; p++)
			if (running[p] && !fin[p]) return 0;
		return 1;
	endfunction

	function automatic logic [2:0] predict_status(req_t q);
		count_t     amt[NUM_RES];
		count_t     av[NUM_RES];
		count_t     hl[NUM_PROCS][NUM_RES];
		count_t     nd[NUM_PROCS][NUM_RES];
		logic [2:0] st;
		int         p;
		amt[0] = q.a0; amt[1] = q.a1; amt[2] = q.a2; amt[3] = q.a3;
		st = ST_DONE;
		p = q.pid;
		if (q.op == OP_LOAD_AVAIL) begin
			for (int r = 0; r < NUM_RES; r++) avail[r] = amt[r];
		end else if (q.op > OP_END || p >= NUM_PROCS) begin
			st = ST_BAD_OP;
		end else if (q.op == OP_LOAD_MAX) begin
			for (int r = 0; r < NUM_RES; r++) begin
				claim[p][r] = amt[r];
				held[p][r] = 0;
				need[p][r] = amt[r];
			end
			running[p] = 1;
		end else if (q.op == OP_REQUEST) begin
			for (int r = 0; r < NUM_RES; r++) begin
				if (st == ST_DONE && amt[r] > need[p][r]) st = ST_EXCEEDS_NEED;
				else if (st == ST_DONE && amt[r] > avail[r]) st = ST_WAIT_INSUFF;
			end
			if (st == ST_DONE) begin
				av = avail; hl = held; nd = need;
				for (int r = 0; r < NUM_RES; r++) begin
					av[r] -= amt[r];
					hl[p][r] = add_sat(hl[p][r], amt[r]);
					nd[p][r] -= amt[r];
				end
				if (state_safe(av, hl, nd)) begin
					avail = av; held = hl; need = nd;
				end else begin
					st = ST_WAIT_UNSAFE;
				end
			end
		end else if (q.op == OP_RELEASE) begin
			for (int r = 0; r < NUM_RES; r++)
				if (amt[r] > held[p][r]) st = ST_BAD_RELEASE;
			if (st == ST_DONE)
				for (int r = 0; r < NUM_RES; r++) begin
					avail[r] = add_sat(avail[r], amt[r]);
					held[p][r] -= amt[r];
					need[p][r] = add_sat(need[p][r], amt[r]);
				end
		end else begin
			for (int r = 0; r < NUM_RES; r++) begin
				avail[r] = add_sat(avail[r], held[p][r]);
				held[p][r] = 0;
				need[p][r] = claim[p][r];
			end
			running[p] = 0;
		end
		return st;
	endfunction

	function automatic req_t make_req(logic [2:0] op, logic [2:0] pid, logic [7:0] a0,
			logic [7:0] a1, logic [7:0] a2, logic [7:0] a3);
		req_t q;
		q.op = op; q.pid = pid; q.a0 = a0; q.a1 = a1; q.a2 = a2; q.a3 = a3;
		return q;
	endfunction

	// Small amounts most of the time so that requests pass and the safety check has work.
	function automatic logic [7:0] rand_amt();
		case ($urandom_range(0, 9))
			0: return 8'($urandom_range(0, 255));
			1: return 8'hff;
			default: return 8'($urandom_range(0, 12));
		endcase
	endfunction

	// Rows of processes never loaded are not touched by request, release or end.
	function automatic req_t rand_req(ref bit ld[NUM_PROCS]);
		req_t q;
		int   k;
		k = $urandom_range(0, 99);
		q = make_req(3'(0), 3'($urandom_range(0, 7)), rand_amt(), rand_amt(), rand_amt(),
			rand_amt());
		if (k < 4) q.op = 3'($urandom_range(5, 7));
		else if (k < 10) q.op = OP_LOAD_AVAIL;
		else if (k < 20 || !ld[q.pid]) q.op = OP_LOAD_MAX;
		else if (k < 70) q.op = OP_REQUEST;
		else if (k < 90) q.op = OP_RELEASE;
		else q.op = OP_END;
		if (q.op == OP_LOAD_AVAIL && $urandom_range(0, 1)) begin
			q.a0 = 8'($urandom_range(20, 255)); q.a1 = 8'($urandom_range(20, 255));
			q.a2 = 8'($urandom_range(20, 255)); q.a3 = 8'($urandom_range(20, 255));
		end
		if (q.op == OP_LOAD_MAX) ld[q.pid] = 1;
		return q;
	endfunction

	task automatic queue_req(req_t q);
		pending_reqs.insert(pending_reqs.size(), q);
	endtask

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			operation <= 0; process <= 0;
			amount_0 <= 0; amount_1 <= 0; amount_2 <= 0; amount_3 <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_status.insert(expected_status.size(), predict_status(make_req(operation,
					process, amount_0, amount_1, amount_2, amount_3)));
				sent++;
			end
			if (!in_valid || !in_stall) begin
				if (driving && !hold_off && pending_reqs.size() > 0 &&
						$urandom_range(0, 99) >= send_idle_pct) begin
					req_t q;
					q = pending_reqs.pop_front();
					in_valid <= 1;
					operation <= q.op; process <= q.pid;
					amount_0 <= q.a0; amount_1 <= q.a1; amount_2 <= q.a2; amount_3 <= q.a3;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_status.size() == 0) begin
					report_mismatch($sformatf("unexpected status %0d", status));
				end else begin
					logic [2:0] want;
					want = expected_status.pop_front();
					checked++;
					if (status !== want)
						report_mismatch($sformatf("status %0d, expected %0d", status, want));
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || in_valid || expected_status.size() > 0)
			@(negedge clk);
	endtask

	initial begin
		bit ld[NUM_PROCS];
		for (int p = 0; p < NUM_PROCS; p++) begin
			ld[p] = 0; running[p] = 0;
			for (int r = 0; r < NUM_RES; r++) begin
				held[p][r] = 0; need[p][r] = 0; claim[p][r] = 0;
			end
		end
		for (int r = 0; r < NUM_RES; r++) avail[r] = 0;
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n = 1;

		queue_req(make_req(OP_LOAD_AVAIL, 3'd0, 8'd10, 8'd5, 8'd7, 8'd0));
		queue_req(make_req(OP_LOAD_MAX, 3'd0, 8'd7, 8'd5, 8'd3, 8'd0));
		queue_req(make_req(OP_LOAD_MAX, 3'd1, 8'd3, 8'd2, 8'd2, 8'd0));
		queue_req(make_req(OP_LOAD_MAX, 3'd7, 8'd9, 8'd0, 8'd2, 8'd0));
		queue_req(make_req(OP_REQUEST, 3'd1, 8'd2, 8'd0, 8'd0, 8'd0));
		queue_req(make_req(OP_REQUEST, 3'd0, 8'd8, 8'd0, 8'd0, 8'd0));
		queue_req(make_req(OP_REQUEST, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		queue_req(make_req(OP_REQUEST, 3'd7, 8'd8, 8'd0, 8'd2, 8'd0));
		queue_req(make_req(OP_REQUEST, 3'd0, 8'd0, 8'd6, 8'd0, 8'd0));
		queue_req(make_req(OP_REQUEST, 3'd0, 8'd5, 8'd5, 8'd3, 8'd0));
		queue_req(make_req(OP_RELEASE, 3'd1, 8'd3, 8'd0, 8'd0, 8'd0));
		queue_req(make_req(OP_RELEASE, 3'd1, 8'd1, 8'd0, 8'd0, 8'd0));
		queue_req(make_req(OP_END, 3'd1, 8'd0, 8'd0, 8'd0, 8'd0));
		queue_req(make_req(OP_END, 3'd1, 8'd0, 8'd0, 8'd0, 8'd0));
		queue_req(make_req(3'd5, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		queue_req(make_req(3'd7, 3'd7, 8'hff, 8'hff, 8'hff, 8'hff));
		queue_req(make_req(OP_LOAD_AVAIL, 3'd6, 8'hff, 8'hff, 8'hff, 8'hff));
		queue_req(make_req(OP_LOAD_MAX, 3'd2, 8'hff, 8'hff, 8'hff, 8'hff));
		queue_req(make_req(OP_REQUEST, 3'd2, 8'hff, 8'hff, 8'hff, 8'hff));
		queue_req(make_req(OP_RELEASE, 3'd2, 8'hff, 8'hff, 8'hff, 8'hff));
		queue_req(make_req(OP_LOAD_MAX, 3'd0, 8'd1, 8'd1, 8'd1, 8'd1));
		queue_req(make_req(OP_END, 3'd7, 8'd0, 8'd0, 8'd0, 8'd0));
		ld[0] = 1; ld[1] = 1; ld[2] = 1; ld[7] = 1;
		driving = 1;
		wait_drained();

		// The sender holds off while requests are queued, and later until all statuses are back.
		hold_off = 1;
		for (int i = 0; i < 40; i++) queue_req(rand_req(ld));
		repeat (5) @(negedge clk);
		hold_off = 0;
		for (int i = 0; i < 190; i++) queue_req(rand_req(ld));
		while (pending_reqs.size() > 115) @(negedge clk);
		hold_off = 1;
		while (in_valid || expected_status.size() > 0) @(negedge clk);
		hold_off = 0;
		wait_drained();

		send_idle_pct = 51; recv_idle_pct = 31;
		for (int i = 0; i < 230; i++) queue_req(rand_req(ld));
		wait_drained();

		send_idle_pct = 0; recv_idle_pct = 0;
		for (int i = 0; i < 240; i++) queue_req(rand_req(ld));
		wait_drained();
		repeat (100) @(posedge clk);

		$display("Sent %0d requests covering every operation, and checked %0d statuses",
			sent, checked);
		$display("under three idling mixes with a full drain in between.");
		if (mismatches == 0 && expected_status.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Timeout with %0d statuses outstanding.", expected_status.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
